/* hw/rtl/lld_pkg.sv */
// lld_pkg: request and status codes and default sizes for the linked list deque
// used by lld_ctrl and linked_list_deque; depends on nothing
package lld_pkg;

  localparam int DEF_NODES      = 64;
  localparam int DEF_DATA_WIDTH = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_INSERT     = 3'd6,
    REQ_READ_NODE  = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_FULL       = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

endpackage

/* hw/rtl/lld_ram.sv */
// lld_ram: single-port synchronous ram with registered read data
// read data holds until the next read; depends on nothing
module lld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/lld_ctrl.sv */
// lld_ctrl: request sequencer, list pointers and free chain bookkeeping
// drives the link and data rams; depends on lld_pkg
module lld_ctrl #(
  parameter int NODES      = lld_pkg::DEF_NODES,
  parameter int DATA_WIDTH = lld_pkg::DEF_DATA_WIDTH,
  localparam int HW = $clog2(NODES + 1),
  localparam int IW = $clog2(NODES),
  localparam int LW = 2 * HW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_req_type,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic [HW-1:0]         in_node_handle,
  output logic                  lnk_re,
  output logic                  lnk_we,
  output logic [IW-1:0]         lnk_addr,
  output logic [LW-1:0]         lnk_wdata,
  input  logic [LW-1:0]         lnk_rdata,
  output logic                  dat_re,
  output logic                  dat_we,
  output logic [IW-1:0]         dat_addr,
  output logic [DATA_WIDTH-1:0] dat_wdata,
  input  logic [DATA_WIDTH-1:0] dat_rdata,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [1:0]            res_status,
  output logic [DATA_WIDTH-1:0] res_data,
  output logic [HW-1:0]         res_handle,
  output logic [HW-1:0]         res_count
);

  localparam logic [HW-1:0] NULLH = HW'(NODES);

  typedef struct packed {
    logic          live;
    logic [HW-1:0] prev;
    logic [HW-1:0] nxt;
  } link_t;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_NODE_WR = 7'b0000010,
    S_NEW_RD  = 7'b0000100,
    S_NEW_WR  = 7'b0001000,
    S_NBR_RD  = 7'b0010000,
    S_NBR_WR  = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  lld_pkg::req_t       req_r, req_nxt, req_in;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [HW-1:0]       hdl_r, hdl_nxt;
  logic [HW-1:0]       head_r, head_nxt;
  logic [HW-1:0]       tail_r, tail_nxt;
  logic [HW-1:0]       cnt_r, cnt_nxt;
  logic [HW-1:0]       free_r, free_nxt;
  logic [HW-1:0]       hwm_r, hwm_nxt;
  lld_pkg::status_t    st_r, st_nxt;
  logic [HW-1:0]       rh_r, rh_nxt;
  logic [HW-1:0]       p_r, p_nxt;
  logic [IW-1:0]       nbr_addr_r, nbr_addr_nxt;
  logic [HW-1:0]       nbr_val_r, nbr_val_nxt;
  logic                nbr_prev_r, nbr_prev_nxt;

  link_t               rd, wr;
  logic [HW-1:0]       free_adv, hwm_adv, x_h, newx;
  logic                full, fresh, has_data;

  assign rd     = link_t'(lnk_rdata);
  assign req_in = lld_pkg::req_t'(in_req_type);
  assign full   = (free_r == NULLH);
  // nodes at or above the high-water mark were never handed out
  assign fresh    = (free_r == hwm_r);
  assign free_adv = fresh ? HW'(free_r + HW'(1)) : rd.nxt;
  assign hwm_adv  = fresh ? HW'(hwm_r + HW'(1)) : hwm_r;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    val_nxt      = val_r;
    hdl_nxt      = hdl_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    free_nxt     = free_r;
    hwm_nxt      = hwm_r;
    st_nxt       = st_r;
    rh_nxt       = rh_r;
    p_nxt        = p_r;
    nbr_addr_nxt = nbr_addr_r;
    nbr_val_nxt  = nbr_val_r;
    nbr_prev_nxt = nbr_prev_r;
    lnk_re       = 1'b0;
    lnk_we       = 1'b0;
    lnk_addr     = '0;
    wr           = '0;
    dat_re       = 1'b0;
    dat_we       = 1'b0;
    dat_addr     = '0;
    dat_wdata    = val_r;
    res_valid    = 1'b0;
    x_h          = (req_r == lld_pkg::REQ_POP_FRONT || req_r == lld_pkg::REQ_PEEK_FRONT) ?
                   head_r : tail_r;
    newx         = (req_r == lld_pkg::REQ_POP_FRONT) ? rd.nxt : rd.prev;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // insert before null is an append at the back
          req_nxt   = (req_in == lld_pkg::REQ_INSERT && in_node_handle == NULLH) ?
                      lld_pkg::REQ_PUSH_BACK : req_in;
          val_nxt   = in_value;
          hdl_nxt   = in_node_handle;
          st_nxt    = lld_pkg::ST_OK;
          rh_nxt    = NULLH;
          state_nxt = S_NODE_WR;
          unique case (req_in) inside
            lld_pkg::REQ_PUSH_FRONT, lld_pkg::REQ_PUSH_BACK: begin
              lnk_re   = 1'b1;
              lnk_addr = free_r[IW-1:0];
            end
            lld_pkg::REQ_POP_FRONT: begin
              lnk_re   = 1'b1;
              lnk_addr = head_r[IW-1:0];
              dat_re   = 1'b1;
              dat_addr = head_r[IW-1:0];
            end
            lld_pkg::REQ_POP_BACK: begin
              lnk_re   = 1'b1;
              lnk_addr = tail_r[IW-1:0];
              dat_re   = 1'b1;
              dat_addr = tail_r[IW-1:0];
            end
            lld_pkg::REQ_PEEK_FRONT: begin
              dat_re   = 1'b1;
              dat_addr = head_r[IW-1:0];
            end
            lld_pkg::REQ_PEEK_BACK: begin
              dat_re   = 1'b1;
              dat_addr = tail_r[IW-1:0];
            end
            lld_pkg::REQ_INSERT: begin
              lnk_re   = 1'b1;
              lnk_addr = (in_node_handle == NULLH) ? free_r[IW-1:0] :
                         in_node_handle[IW-1:0];
            end
            lld_pkg::REQ_READ_NODE: begin
              lnk_re   = 1'b1;
              lnk_addr = in_node_handle[IW-1:0];
              dat_re   = 1'b1;
              dat_addr = in_node_handle[IW-1:0];
            end
          endcase
        end
      end

      S_NODE_WR: begin
        state_nxt = S_DONE;
        unique case (req_r) inside
          lld_pkg::REQ_PUSH_FRONT, lld_pkg::REQ_PUSH_BACK: begin
            if (full) begin
              st_nxt = lld_pkg::ST_FULL;
            end else begin
              lnk_we   = 1'b1;
              lnk_addr = free_r[IW-1:0];
              wr.live  = 1'b1;
              dat_we   = 1'b1;
              dat_addr = free_r[IW-1:0];
              free_nxt = free_adv;
              hwm_nxt  = hwm_adv;
              cnt_nxt  = HW'(cnt_r + HW'(1));
              rh_nxt   = free_r;
              if (req_r == lld_pkg::REQ_PUSH_FRONT) begin
                wr.prev  = NULLH;
                wr.nxt   = head_r;
                head_nxt = free_r;
                if (tail_r == NULLH) begin
                  tail_nxt = free_r;
                end
                if (head_r != NULLH) begin
                  nbr_addr_nxt = head_r[IW-1:0];
                  nbr_val_nxt  = free_r;
                  nbr_prev_nxt = 1'b1;
                  state_nxt    = S_NBR_RD;
                end
              end else begin
                wr.prev  = tail_r;
                wr.nxt   = NULLH;
                tail_nxt = free_r;
                if (head_r == NULLH) begin
                  head_nxt = free_r;
                end
                if (tail_r != NULLH) begin
                  nbr_addr_nxt = tail_r[IW-1:0];
                  nbr_val_nxt  = free_r;
                  nbr_prev_nxt = 1'b0;
                  state_nxt    = S_NBR_RD;
                end
              end
            end
          end
          lld_pkg::REQ_POP_FRONT, lld_pkg::REQ_POP_BACK: begin
            if (x_h == NULLH) begin
              st_nxt = lld_pkg::ST_EMPTY;
            end else begin
              // retired node goes to the front of the free chain
              lnk_we   = 1'b1;
              lnk_addr = x_h[IW-1:0];
              wr.live  = 1'b0;
              wr.prev  = rd.prev;
              wr.nxt   = free_r;
              free_nxt = x_h;
              cnt_nxt  = HW'(cnt_r - HW'(1));
              if (req_r == lld_pkg::REQ_POP_FRONT) begin
                head_nxt = newx;
                if (newx == NULLH) begin
                  tail_nxt = NULLH;
                end
              end else begin
                tail_nxt = newx;
                if (newx == NULLH) begin
                  head_nxt = NULLH;
                end
              end
              if (newx != NULLH) begin
                nbr_addr_nxt = newx[IW-1:0];
                nbr_val_nxt  = NULLH;
                nbr_prev_nxt = (req_r == lld_pkg::REQ_POP_FRONT);
                state_nxt    = S_NBR_RD;
              end
            end
          end
          lld_pkg::REQ_PEEK_FRONT, lld_pkg::REQ_PEEK_BACK: begin
            if (x_h == NULLH) begin
              st_nxt = lld_pkg::ST_EMPTY;
            end else begin
              rh_nxt = x_h;
            end
          end
          lld_pkg::REQ_READ_NODE: begin
            if (hdl_r < hwm_r && rd.live) begin
              rh_nxt = rd.nxt;
            end else begin
              st_nxt = lld_pkg::ST_BAD_HANDLE;
            end
          end
          lld_pkg::REQ_INSERT: begin
            if (!(hdl_r < hwm_r && rd.live)) begin
              st_nxt = lld_pkg::ST_BAD_HANDLE;
            end else if (full) begin
              st_nxt = lld_pkg::ST_FULL;
            end else begin
              lnk_we    = 1'b1;
              lnk_addr  = hdl_r[IW-1:0];
              wr.live   = rd.live;
              wr.prev   = free_r;
              wr.nxt    = rd.nxt;
              p_nxt     = rd.prev;
              state_nxt = S_NEW_RD;
            end
          end
        endcase
      end

      S_NEW_RD: begin
        lnk_re    = 1'b1;
        lnk_addr  = free_r[IW-1:0];
        state_nxt = S_NEW_WR;
      end

      S_NEW_WR: begin
        lnk_we    = 1'b1;
        lnk_addr  = free_r[IW-1:0];
        wr.live   = 1'b1;
        wr.prev   = p_r;
        wr.nxt    = hdl_r;
        dat_we    = 1'b1;
        dat_addr  = free_r[IW-1:0];
        free_nxt  = free_adv;
        hwm_nxt   = hwm_adv;
        cnt_nxt   = HW'(cnt_r + HW'(1));
        rh_nxt    = free_r;
        state_nxt = S_DONE;
        if (p_r != NULLH) begin
          nbr_addr_nxt = p_r[IW-1:0];
          nbr_val_nxt  = free_r;
          nbr_prev_nxt = 1'b0;
          state_nxt    = S_NBR_RD;
        end else begin
          head_nxt = free_r;
        end
      end

      S_NBR_RD: begin
        lnk_re    = 1'b1;
        lnk_addr  = nbr_addr_r;
        state_nxt = S_NBR_WR;
      end

      S_NBR_WR: begin
        lnk_we    = 1'b1;
        lnk_addr  = nbr_addr_r;
        wr        = rd;
        if (nbr_prev_r) begin
          wr.prev = nbr_val_r;
        end else begin
          wr.nxt  = nbr_val_r;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign lnk_wdata = wr;

  assign has_data = (req_r == lld_pkg::REQ_POP_FRONT) || (req_r == lld_pkg::REQ_POP_BACK) ||
                    (req_r == lld_pkg::REQ_PEEK_FRONT) || (req_r == lld_pkg::REQ_PEEK_BACK) ||
                    (req_r == lld_pkg::REQ_READ_NODE);

  // data ram output holds from the read issued at accept
  assign res_status = st_r;
  assign res_data   = (st_r == lld_pkg::ST_OK && has_data) ? dat_rdata : '0;
  assign res_handle = rh_r;
  assign res_count  = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= NULLH;
      tail_r  <= NULLH;
      cnt_r   <= '0;
      free_r  <= '0;
      hwm_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      free_r  <= free_nxt;
      hwm_r   <= hwm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    val_r      <= val_nxt;
    hdl_r      <= hdl_nxt;
    st_r       <= st_nxt;
    rh_r       <= rh_nxt;
    p_r        <= p_nxt;
    nbr_addr_r <= nbr_addr_nxt;
    nbr_val_r  <= nbr_val_nxt;
    nbr_prev_r <= nbr_prev_nxt;
  end

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r == NULLH) == (cnt_r == NULLH))
    else $error("free chain empty does not match a full pool");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((head_r == NULLH) == (cnt_r == '0)) && ((tail_r == NULLH) == (cnt_r == '0)))
    else $error("head or tail pointer disagrees with element count");

  a_free_below_hwm: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= hwm_r)
    else $error("free head beyond high-water mark");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r)) || (cnt_r == HW'($past(cnt_r) + HW'(1))) ||
                     (cnt_r == HW'($past(cnt_r) - HW'(1))))
    else $error("element count moved by more than one");

endmodule

/* hw/rtl/linked_list_deque.sv */
// linked_list_deque: doubly linked list deque over a self-managed node pool
// depends on lld_pkg, lld_ram and lld_ctrl
//
// Usage: one request beat on the in_ channel (valid/ready) gives exactly one
// result beat on the out_ channel. in_req_type picks push, pop or peek at
// either end, insert before in_node_handle (null handle appends at the back)
// or read a node and its successor. The null handle equals NODES. Every
// result carries a status (ok, empty, pool full, bad handle) and the live
// element count after the request.
// Timing: requests are handled one at a time, each through a node write state
// and a done state that loads the output register. Push and pop that relink a
// neighbor add a neighbor read and write; insert before a node adds a new node
// read and write and, unless the new node becomes head, the neighbor pair. The
// single-port link ram sets this: each relinked node costs a read and a write.
// in_ready returns the cycle after the result leaves the sequencer, so the next
// request overlaps a result still waiting on out_.
// Reset: the pool is usable in the first cycle after reset; no memory sweep is
// needed since never-used nodes are tracked by a high-water mark.
// Stall: while out_ready is low the result is held and the sequencer waits
// with its next result, accepting no further request.
module linked_list_deque #(
  parameter int NODES      = lld_pkg::DEF_NODES,
  parameter int DATA_WIDTH = lld_pkg::DEF_DATA_WIDTH,
  localparam int HW = $clog2(NODES + 1),
  localparam int IW = $clog2(NODES),
  localparam int LW = 2 * HW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_req_type,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic [HW-1:0]         in_node_handle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [DATA_WIDTH-1:0] out_data,
  output logic [HW-1:0]         out_result_handle,
  output logic [HW-1:0]         out_element_count
);

  logic                  lnk_re, lnk_we, dat_re, dat_we;
  logic [IW-1:0]         lnk_addr, dat_addr;
  logic [LW-1:0]         lnk_wdata, lnk_rdata;
  logic [DATA_WIDTH-1:0] dat_wdata, dat_rdata;
  logic                  res_valid, res_ready;
  logic [1:0]            res_status;
  logic [DATA_WIDTH-1:0] res_data;
  logic [HW-1:0]         res_handle, res_count;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic [HW-1:0]         out_handle_r, out_count_r;

  lld_ram #(.WIDTH(LW), .DEPTH(NODES)) u_link_ram (
    .clk   (clk),
    .re    (lnk_re),
    .we    (lnk_we),
    .addr  (lnk_addr),
    .wdata (lnk_wdata),
    .rdata (lnk_rdata)
  );

  lld_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_data_ram (
    .clk   (clk),
    .re    (dat_re),
    .we    (dat_we),
    .addr  (dat_addr),
    .wdata (dat_wdata),
    .rdata (dat_rdata)
  );

  lld_ctrl #(.NODES(NODES), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .in_node_handle (in_node_handle),
    .lnk_re         (lnk_re),
    .lnk_we         (lnk_we),
    .lnk_addr       (lnk_addr),
    .lnk_wdata      (lnk_wdata),
    .lnk_rdata      (lnk_rdata),
    .dat_re         (dat_re),
    .dat_we         (dat_we),
    .dat_addr       (dat_addr),
    .dat_wdata      (dat_wdata),
    .dat_rdata      (dat_rdata),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_status     (res_status),
    .res_data       (res_data),
    .res_handle     (res_handle),
    .res_count      (res_count)
  );

  // output register takes a new beat when empty or being drained
  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res_status;
      out_data_r   <= res_data;
      out_handle_r <= res_handle;
      out_count_r  <= res_count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_data          = out_data_r;
  assign out_result_handle = out_handle_r;
  assign out_element_count = out_count_r;

endmodule

/* verif/lld_checker.sv */
// lld_checker: watches the request and result channels of linked_list_deque,
// keeps its own copy of the node pool and list, and compares every result beat
// depends on lld_pkg
module lld_checker
  import lld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_value,
  input  logic [6:0]  in_node_handle,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_data,
  input  logic [6:0]  out_result_handle,
  input  logic [6:0]  out_element_count,
  output int          fail_count,
  output int          outstanding
);

  localparam int NODES = DEF_NODES;
  localparam logic [6:0] NULL_H = 7'(NODES);
  localparam int EXP_DEPTH = 8;

  typedef struct {
    status_t     status;
    logic [31:0] data;
    logic [6:0]  handle;
    logic [6:0]  count;
  } deque_result_t;

  logic [31:0] node_val [NODES];
  logic [6:0]  fwd [NODES];
  logic [6:0]  back [NODES];
  bit          used [NODES];
  logic [6:0]  head_h, tail_h, live_n, free_h;

  // expected results in request order
  deque_result_t exp_fifo [EXP_DEPTH];
  int            exp_wr, exp_rd;
  deque_result_t want;

  function automatic bit in_pool(input logic [6:0] h);
    return h < NULL_H;
  endfunction

  // caller has checked that the free chain is not empty
  function automatic logic [6:0] alloc_node(input logic [31:0] v);
    logic [6:0] n;
    n = free_h;
    free_h = fwd[n[5:0]];
    used[n[5:0]] = 1'b1;
    node_val[n[5:0]] = v;
    return n;
  endfunction

  function automatic void free_node(input logic [6:0] n);
    used[n[5:0]] = 1'b0;
    fwd[n[5:0]] = free_h;
    free_h = n;
  endfunction

  function automatic logic [6:0] append_node(input logic [31:0] v);
    logic [6:0] n;
    n = alloc_node(v);
    back[n[5:0]] = tail_h;
    fwd[n[5:0]] = NULL_H;
    if (in_pool(tail_h)) fwd[tail_h[5:0]] = n;
    tail_h = n;
    if (!in_pool(head_h)) head_h = n;
    live_n++;
    return n;
  endfunction

  function automatic deque_result_t apply_request(input req_t req, input logic [31:0] v,
                                                  input logic [6:0] h);
    deque_result_t r;
    logic [6:0] n, p;
    bit full;
    r.status = ST_OK;
    r.data = '0;
    r.handle = NULL_H;
    full = !in_pool(free_h);
    case (req)
      REQ_PUSH_FRONT: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          n = alloc_node(v);
          fwd[n[5:0]] = head_h;
          back[n[5:0]] = NULL_H;
          if (in_pool(head_h)) back[head_h[5:0]] = n;
          head_h = n;
          if (!in_pool(tail_h)) tail_h = n;
          live_n++;
          r.handle = n;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) r.status = ST_FULL;
        else r.handle = append_node(v);
      end
      REQ_POP_FRONT: begin
        if (!in_pool(head_h)) begin
          r.status = ST_EMPTY;
        end else begin
          n = head_h;
          r.data = node_val[n[5:0]];
          head_h = fwd[n[5:0]];
          if (in_pool(head_h)) back[head_h[5:0]] = NULL_H;
          else tail_h = NULL_H;
          free_node(n);
          live_n--;
        end
      end
      REQ_POP_BACK: begin
        if (!in_pool(tail_h)) begin
          r.status = ST_EMPTY;
        end else begin
          n = tail_h;
          r.data = node_val[n[5:0]];
          tail_h = back[n[5:0]];
          if (in_pool(tail_h)) fwd[tail_h[5:0]] = NULL_H;
          else head_h = NULL_H;
          free_node(n);
          live_n--;
        end
      end
      REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        n = (req == REQ_PEEK_FRONT) ? head_h : tail_h;
        if (!in_pool(n)) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = node_val[n[5:0]];
          r.handle = n;
        end
      end
      REQ_INSERT: begin
        // null target appends; a bad target is flagged before a full pool
        if (h == NULL_H) begin
          if (full) r.status = ST_FULL;
          else r.handle = append_node(v);
        end else if (!in_pool(h) || !used[h[5:0]]) begin
          r.status = ST_BAD_HANDLE;
        end else if (full) begin
          r.status = ST_FULL;
        end else begin
          n = alloc_node(v);
          p = back[h[5:0]];
          fwd[n[5:0]] = h;
          back[n[5:0]] = p;
          if (in_pool(p)) fwd[p[5:0]] = n;
          else head_h = n;
          back[h[5:0]] = n;
          live_n++;
          r.handle = n;
        end
      end
      default: begin
        if (!in_pool(h) || !used[h[5:0]]) begin
          r.status = ST_BAD_HANDLE;
        end else begin
          r.data = node_val[h[5:0]];
          r.handle = fwd[h[5:0]];
        end
      end
    endcase
    r.count = live_n;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
    $display("mismatch %s: got %0h, expected %0h", what, got, exp_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        node_val[i] = '0;
        fwd[i] = 7'(i + 1);
        back[i] = NULL_H;
        used[i] = 1'b0;
      end
      head_h = NULL_H;
      tail_h = NULL_H;
      live_n = '0;
      free_h = '0;
      exp_wr = 0;
      exp_rd = 0;
      outstanding = 0;
    end else begin
      // compare before predicting so a beat can never match its own request
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          report("result beat with nothing pending", {30'd0, out_status}, 32'd0);
        end else begin
          want = exp_fifo[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_status !== want.status)
            report("status", {30'd0, out_status}, {30'd0, want.status});
          if (out_data !== want.data)
            report("data", out_data, want.data);
          if (out_result_handle !== want.handle)
            report("handle", {25'd0, out_result_handle}, {25'd0, want.handle});
          if (out_element_count !== want.count)
            report("count", {25'd0, out_element_count}, {25'd0, want.count});
        end
      end
      if (in_valid && in_ready) begin
        if (exp_wr - exp_rd >= EXP_DEPTH)
          report("too many pending requests", 32'(exp_wr - exp_rd), 32'(EXP_DEPTH));
        exp_fifo[exp_wr % EXP_DEPTH] = apply_request(req_t'(in_req_type), in_value,
                                                     in_node_handle);
        exp_wr++;
      end
      outstanding = exp_wr - exp_rd;
    end
  end

endmodule

/* verif/testbench.sv */
// testbench: drives request beats into linked_list_deque with random stalls on
// both channels and gives the verdict from the lld_checker failure count
// depends on lld_pkg, lld_checker and the linked_list_deque rtl
module testbench;
  import lld_pkg::*;

  localparam logic [6:0] NULL_H = 7'(DEF_NODES);

  typedef enum {GROW, SHRINK, MIXED} mix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_req_type = '0;
  logic [31:0] in_value = '0;
  logic [6:0]  in_node_handle = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_data;
  logic [6:0]  out_result_handle;
  logic [6:0]  out_element_count;

  int fail_count;
  int outstanding;
  int send_idle = 25;
  int recv_idle = 87;

  linked_list_deque u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .in_node_handle    (in_node_handle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_data          (out_data),
    .out_result_handle (out_result_handle),
    .out_element_count (out_element_count)
  );

  lld_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .in_node_handle    (in_node_handle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_data          (out_data),
    .out_result_handle (out_result_handle),
    .out_element_count (out_element_count),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ready = rst_n && ($urandom_range(99) >= recv_idle);
  end

  // valid stays high between back-to-back beats; it only drops for a gap
  task automatic send_req(input req_t req, input logic [31:0] v, input logic [6:0] h);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req_type = req;
    in_value = v;
    in_node_handle = h;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int idx, r, hsel;
    int w_push, w_ins, w_pop, w_peek;
    mix_t mode;
    logic [6:0] h;
    req_t req;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // empty list: pops and peeks, then bad targets
    send_req(REQ_POP_FRONT, 32'h0, NULL_H);
    send_req(REQ_POP_BACK, 32'h0, NULL_H);
    send_req(REQ_PEEK_FRONT, 32'h0, NULL_H);
    send_req(REQ_PEEK_BACK, 32'h0, NULL_H);
    send_req(REQ_READ_NODE, 32'h0, NULL_H);
    send_req(REQ_READ_NODE, 32'h0, 7'd127);
    send_req(REQ_READ_NODE, 32'h0, 7'd5);
    send_req(REQ_INSERT, 32'h1234_5678, 7'd100);
    send_req(REQ_INSERT, 32'h1234_5678, 7'd3);
    // build 4 -> 1 -> 3 -> 0 -> 2
    send_req(REQ_PUSH_BACK, 32'hFFFF_FFFF, 7'd0);
    send_req(REQ_PUSH_FRONT, 32'h0, 7'd127);
    send_req(REQ_INSERT, 32'hA5A5_A5A5, NULL_H);
    send_req(REQ_INSERT, 32'h5A5A_5A5A, 7'd0);
    send_req(REQ_INSERT, 32'h8000_0001, 7'd1);
    send_req(REQ_PEEK_FRONT, 32'h0, 7'd0);
    send_req(REQ_PEEK_BACK, 32'h0, 7'd0);
    send_req(REQ_READ_NODE, 32'h0, 7'd4);
    send_req(REQ_READ_NODE, 32'h0, 7'd2);
    send_req(REQ_READ_NODE, 32'h0, 7'd3);
    send_req(REQ_POP_BACK, 32'h0, 7'd0);
    send_req(REQ_POP_FRONT, 32'h0, 7'd0);
    send_req(REQ_POP_FRONT, 32'h0, 7'd0);
    send_req(REQ_POP_BACK, 32'h0, 7'd0);
    send_req(REQ_POP_FRONT, 32'h0, 7'd0);
    send_req(REQ_READ_NODE, 32'h0, 7'd0);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 25; recv_idle = 87; end
        1: begin send_idle = 87; recv_idle = 25; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int k = 0; k < 250; k++) begin
        idx = phase * 250 + k;
        // runs of growth and shrinkage carry the pool to full and back to empty
        case ((idx / 50) % 6)
          0, 1: mode = GROW;
          3, 4: mode = SHRINK;
          default: mode = MIXED;
        endcase
        case (mode)
          GROW: begin w_push = 78; w_ins = 12; w_pop = 4; w_peek = 2; end
          SHRINK: begin w_push = 8; w_ins = 4; w_pop = 80; w_peek = 4; end
          default: begin w_push = 25; w_ins = 20; w_pop = 25; w_peek = 10; end
        endcase
        hsel = $urandom_range(99);
        if (hsel < 84) h = 7'($urandom_range(DEF_NODES - 1));
        else if (hsel < 92) h = NULL_H;
        else h = 7'($urandom_range(127, DEF_NODES + 1));
        r = $urandom_range(99);
        if (r < w_push)
          req = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else if (r < w_push + w_ins)
          req = REQ_INSERT;
        else if (r < w_push + w_ins + w_pop)
          req = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        else if (r < w_push + w_ins + w_pop + w_peek)
          req = $urandom_range(1) ? REQ_PEEK_BACK : REQ_PEEK_FRONT;
        else
          req = REQ_READ_NODE;
        send_req(req, $urandom(), h);
      end
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
